### hdl/ptct_pkg.sv
`default_nettype none

package ptct_pkg;

    localparam int unsigned TIME_W    = 63;
    localparam int unsigned PERIOD_W  = 32;
    localparam int unsigned PENDING_W = 32;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD   = 32'd900000;
    localparam logic [9:0]          MISSED_LIMIT = 10'd1000;

    // the period is never below 2^19, so the quotient of a 63-bit span fits in 44 bits
    localparam int unsigned QUOT_W = TIME_W - 19;
    localparam int unsigned CNT_W  = $clog2(QUOT_W);

    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_EXPIRE = 2'd1,
        ACT_PICKUP = 2'd2,
        ACT_STOP   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]        action;
        logic [TIME_W-1:0] now_ns;
        logic              vcpu_running;
        logic              timer_armed;
    } t_in_word;

    typedef struct packed {
        logic [PENDING_W-1:0] pending_ticks;
        logic [TIME_W-1:0]    deadline_ns;
        logic                 arm_timer;
        logic                 disarm_timer;
        logic                 enabled;
    } t_out_word;

endpackage

`default_nettype wire

### hdl/periodic_tick_catchup_timer_top.sv
// flow: start, stop and armed pickup go from accept straight to the output state;
// expire and unarmed pickup pass a compare state first, then output when the deadline
// is not passed, else a 44-step restoring divider (one quotient bit per cycle on one
// 33-bit subtractor) and a finish state run first; the output state waits while stalled
// one word at a time: the next is accepted once the result is registered
// reset: synchronous active-low, clears counts, deadline, enable and valid; period 900000
`default_nettype none

module periodic_tick_catchup_timer_top
    import ptct_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire t_in_word            i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output t_out_word                o_out_word
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CMP  = 5'b00010,
        S_DIV  = 5'b00100,
        S_FIN  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [PERIOD_W-1:0]   r_period;
    logic [PERIOD_W-1:0]   r_held, n_held;
    logic [PENDING_W-1:0]  r_pend, n_pend;
    logic [TIME_W-1:0]     r_dl, n_dl;
    logic                  r_running, n_running;
    logic                  r_arm, n_arm;
    logic                  r_disarm, n_disarm;
    logic [TIME_W-1:0]     r_now, n_now;
    logic [PERIOD_W-1:0]   r_rem, n_rem;
    logic [QUOT_W-1:0]     r_quot, n_quot;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;
    t_out_word             r_out, n_out;

    logic                  in_acc;
    logic                  out_free;
    logic [TIME_W-1:0]     diff;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     shifted;
    logic [PENDING_W:0]    pend_sum;
    logic [PENDING_W-1:0]  pend_inc;
    logic [PERIOD_W-1:0]   per_clamped;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign diff        = r_now - r_dl;
    assign shifted     = {r_rem, r_quot[QUOT_W-1]};
    assign trial       = shifted - {1'b0, r_held};
    assign per_clamped = (r_period < MIN_PERIOD) ? MIN_PERIOD : r_period;
    assign pend_inc    = (r_quot >= QUOT_W'(MISSED_LIMIT)) ? PENDING_W'(1)
                                                           : PENDING_W'(r_quot[9:0]) + 1'b1;
    assign pend_sum    = {1'b0, r_pend} + {1'b0, pend_inc};

    always_comb begin
        n_state     = r_state;
        n_held      = r_held;
        n_pend      = r_pend;
        n_dl        = r_dl;
        n_running   = r_running;
        n_arm       = r_arm;
        n_disarm    = r_disarm;
        n_now       = r_now;
        n_rem       = r_rem;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_now    = i_in_word.now_ns;
                    n_arm    = 1'b0;
                    n_disarm = 1'b0;
                    n_state  = S_DONE;
                    case (t_action'(i_in_word.action))
                        ACT_START: begin
                            n_disarm  = r_running;
                            n_held    = per_clamped;
                            n_pend    = '0;
                            n_dl      = i_in_word.now_ns + TIME_W'(per_clamped);
                            n_running = 1'b1;
                            n_arm     = 1'b1;
                        end
                        ACT_EXPIRE: begin
                            if (r_pend != '1) begin
                                n_pend = r_pend + 1'b1;
                            end
                            n_dl    = r_dl + TIME_W'(r_held);
                            n_arm   = i_in_word.vcpu_running;
                            n_state = S_CMP;
                        end
                        ACT_PICKUP: begin
                            if (!i_in_word.timer_armed) begin
                                n_arm   = 1'b1;
                                n_state = S_CMP;
                            end
                        end
                        default: begin
                            n_disarm  = r_running;
                            n_running = 1'b0;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (r_now > r_dl) begin
                    n_rem   = PERIOD_W'(diff[TIME_W-1:QUOT_W]);
                    n_quot  = diff[QUOT_W-1:0];
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                // restoring step, quotient bits shift in behind the dividend bits
                if (!trial[PERIOD_W]) begin
                    n_rem = trial[PERIOD_W-1:0];
                end else begin
                    n_rem = shifted[PERIOD_W-1:0];
                end
                n_quot = {r_quot[QUOT_W-2:0], !trial[PERIOD_W]};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // deadline + (q+1)*per equals now - rem + per
                n_dl    = r_now - TIME_W'(r_rem) + TIME_W'(r_held);
                n_pend  = pend_sum[PENDING_W] ? '1 : pend_sum[PENDING_W-1:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid         = 1'b1;
                    n_out.pending_ticks = r_pend;
                    n_out.deadline_ns   = r_dl;
                    n_out.arm_timer     = r_arm;
                    n_out.disarm_timer  = r_disarm;
                    n_out.enabled       = r_running;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_period    <= MIN_PERIOD;
            r_held      <= MIN_PERIOD;
            r_pend      <= '0;
            r_dl        <= '0;
            r_running   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            r_held      <= n_held;
            r_pend      <= n_pend;
            r_dl        <= n_dl;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_arm    <= n_arm;
        r_disarm <= n_disarm;
        r_now    <= n_now;
        r_rem    <= n_rem;
        r_quot   <= n_quot;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

`ifndef SYNTH
    a_held_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held >= MIN_PERIOD)
        else $error("latched period below minimum");

    a_rem_below_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_held))
        else $error("divider remainder not below period");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(QUOT_W)))
        else $error("divider step count out of range");

    a_start_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_word.action == ACT_START) |=> (r_state == S_DONE && r_running))
        else $error("start did not complete directly");
`endif

endmodule

`default_nettype wire
